>>> rtl/bcpg_pkg.sv
// shared types and constants for the bounding circle point grow block
package bcpg_pkg;

    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = 31;
    localparam int ROOT_W     = 33;
    localparam int CSUB_W     = 36;
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 32;
    localparam int CNT_W      = $clog2(SQRT_STEPS);
    localparam int IDX_W      = 2;

    localparam logic [IDX_W-1:0] REG_INIT_CX = 2'd0;
    localparam logic [IDX_W-1:0] REG_INIT_CY = 2'd1;
    localparam logic [IDX_W-1:0] REG_INIT_R  = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

    typedef struct packed {
        logic                      first;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RADIUS_W-1:0]       radius;
        logic                      grew;
    } out_item_t;

    typedef struct packed {
        logic [CSUB_W-1:0] diff;
        logic              ge;
    } csub_res_t;

endpackage

>>> rtl/bcpg_mul.sv
// shared 32x32 unsigned multiplier with registered product
module bcpg_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    always_ff @(posedge clk)
    begin
        p <= 64'(a) * 64'(b);
    end

endmodule

>>> rtl/bcpg_csub.sv
// shared compare and subtract step for square root and division
module bcpg_csub (
    input  logic [bcpg_pkg::CSUB_W-1:0] minuend,
    input  logic [bcpg_pkg::CSUB_W-1:0] subtrahend,
    output bcpg_pkg::csub_res_t         res
);

    logic [bcpg_pkg::CSUB_W:0] d;

    assign d        = {1'b0, minuend} - {1'b0, subtrahend};
    assign res.ge   = ~d[bcpg_pkg::CSUB_W];
    assign res.diff = d[bcpg_pkg::CSUB_W-1:0];

endmodule

>>> rtl/bounding_circle_point_grow.sv
// top level: sequencer, circle state and configuration registers
// A point on or inside the circle goes from accept through the squares and the
// compare to the result; a point outside takes five products in all on the shared
// multiplier, a 33-step bit-pair square root and two 32-step long divisions,
// the root and the divisions on one shared compare-subtract unit, one step per
// cycle. in_ready is high only while the sequencer is idle; a finished result
// sits in the output register so the next item can be accepted while it waits.
// Configuration writes take effect on the next item flagged first.
module bounding_circle_point_grow (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bcpg_pkg::IDX_W-1:0]     cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bcpg_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bcpg_pkg::out_item_t            out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SX, S_SY, S_RR, S_CMP, S_SQRT, S_GROW,
        S_MUL, S_LOAD, S_DIV, S_APPLY, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [31:0] init_cx_reg, init_cy_reg, cx_reg, cy_reg;
    logic [30:0]        init_r_reg, r_reg, nr_reg, growth_reg;
    logic [31:0]        ax_reg, ay_reg, qsh_reg;
    logic               nx_reg, ny_reg, axis_reg, grew_reg, out_valid_reg;
    logic [64:0]        d_reg;
    logic [65:0]        dsh_reg;
    logic [34:0]        rem_reg;
    logic [32:0]        root_reg;
    logic [bcpg_pkg::CNT_W-1:0] cnt_reg;
    bcpg_pkg::out_item_t        out_reg;

    // operand mux for the shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [bcpg_pkg::CSUB_W-1:0] cs_min, cs_sub;
    bcpg_pkg::csub_res_t cs_res;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SX:    begin mul_a = ax_reg; mul_b = ax_reg; end
            S_SY:    begin mul_a = ay_reg; mul_b = ay_reg; end
            S_RR:    begin mul_a = {1'b0, r_reg}; mul_b = {1'b0, r_reg}; end
            S_MUL:   begin mul_a = axis_reg ? ay_reg : ax_reg; mul_b = {1'b0, growth_reg}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            cs_min = {rem_reg[33:0], dsh_reg[65:64]};
            cs_sub = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            cs_min = {2'b00, rem_reg[32:0], qsh_reg[31]};
            cs_sub = {3'b000, root_reg};
        end
    end

    bcpg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
    bcpg_csub u_csub (.minuend(cs_min), .subtrahend(cs_sub), .res(cs_res));

    // difference to the center at accept, with the reload folded in
    logic signed [31:0] cx_eff, cy_eff;
    logic signed [32:0] dx, dy, adx, ady;

    assign cx_eff = in_data.first ? init_cx_reg : cx_reg;
    assign cy_eff = in_data.first ? init_cy_reg : cy_reg;
    assign dx  = 33'(in_data.point_x) - 33'(cx_eff);
    assign dy  = 33'(in_data.point_y) - 33'(cy_eff);
    assign adx = dx[32] ? -dx : dx;
    assign ady = dy[32] ? -dy : dy;

    // new radius from the root
    logic [33:0] rsum;
    logic [30:0] nr;
    assign rsum = {3'b000, r_reg} + {1'b0, root_reg};
    assign nr   = (rsum[33:32] != 2'b00) ? bcpg_pkg::RADIUS_MAX : rsum[31:1];

    // center step with saturation
    logic signed [31:0] base;
    logic signed [32:0] step;
    logic signed [33:0] csum;
    logic signed [31:0] csat;

    assign base = axis_reg ? cy_reg : cx_reg;
    assign step = (axis_reg ? ny_reg : nx_reg) ? -{1'b0, qsh_reg} : {1'b0, qsh_reg};
    assign csum = 34'(base) + 34'(step);
    always_comb
    begin
        if (csum[33:31] == 3'b000 || csum[33:31] == 3'b111)
            csat = csum[31:0];
        else if (csum[33])
            csat = {1'b1, 31'd0};
        else
            csat = {1'b0, {31{1'b1}}};
    end

    // result register loads this cycle
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_cx_reg   <= '0;
            init_cy_reg   <= '0;
            init_r_reg    <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            grew_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bcpg_pkg::REG_INIT_CX: init_cx_reg <= cfg_data;
                    bcpg_pkg::REG_INIT_CY: init_cy_reg <= cfg_data;
                    bcpg_pkg::REG_INIT_R:  init_r_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.first)
                        begin
                            cx_reg <= init_cx_reg;
                            cy_reg <= init_cy_reg;
                            r_reg  <= init_r_reg;
                        end
                        ax_reg    <= adx[31:0];
                        ay_reg    <= ady[31:0];
                        nx_reg    <= dx[32];
                        ny_reg    <= dy[32];
                        state_reg <= S_SX;
                    end
                end
                S_SX:
                    state_reg <= S_SY;
                S_SY:
                begin
                    d_reg     <= {1'b0, prod};
                    state_reg <= S_RR;
                end
                S_RR:
                begin
                    d_reg     <= d_reg + {1'b0, prod};
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (d_reg > {1'b0, prod})
                    begin
                        dsh_reg   <= {1'b0, d_reg};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        grew_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_SQRT:
                begin
                    rem_reg  <= cs_res.ge ? cs_res.diff[34:0] : cs_min[34:0];
                    root_reg <= {root_reg[31:0], cs_res.ge};
                    dsh_reg  <= {dsh_reg[63:0], 2'b00};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == bcpg_pkg::CNT_W'(bcpg_pkg::SQRT_STEPS - 1))
                        state_reg <= S_GROW;
                end
                S_GROW:
                begin
                    nr_reg     <= nr;
                    growth_reg <= nr - r_reg;
                    axis_reg   <= 1'b0;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_LOAD;
                S_LOAD:
                begin
                    // high half is below the divisor since the quotient fits in 32 bits
                    rem_reg   <= {3'b000, prod[63:32]};
                    qsh_reg   <= prod[31:0];
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= cs_res.ge ? cs_res.diff[34:0] : cs_min[34:0];
                    qsh_reg <= {qsh_reg[30:0], cs_res.ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == bcpg_pkg::CNT_W'(bcpg_pkg::DIV_STEPS - 1))
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (!axis_reg)
                    begin
                        cx_reg    <= csat;
                        axis_reg  <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cy_reg    <= csat;
                        r_reg     <= nr_reg;
                        grew_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg.center_x <= cx_reg;
                        out_reg.center_y <= cy_reg;
                        out_reg.radius   <= r_reg;
                        out_reg.grew     <= grew_reg;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SX))
        else $error("accepted item did not start the sequence");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < {2'b00, root_reg}))
        else $error("division remainder not below divisor");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output state");

    a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (cnt_reg < bcpg_pkg::CNT_W'(bcpg_pkg::SQRT_STEPS)))
        else $error("square root step count overrun");

endmodule
